[rtl/prfr_pkg.sv]
// Package for the probe reply frame receiver.
// Holds the item and result types, frame constants and the CRC-16 byte update.
// No dependencies.
`default_nettype none

package prfr_pkg;

    localparam int unsigned FRAME_LEN = 28;
    localparam int unsigned CRC_SPAN  = 26;
    localparam int unsigned HDR_LEN   = 6;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [9:0]  TIMEOUT_RESET = 10'd150;

    // Little-endian field offsets within the reply
    localparam logic [4:0] OFS_CURRENT = 5'd6;
    localparam logic [4:0] OFS_ENERGY  = 5'd10;
    localparam logic [4:0] OFS_COUNT   = 5'd14;
    localparam logic [4:0] OFS_MINIMUM = 5'd18;
    localparam logic [4:0] OFS_AVERAGE = 5'd22;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CRC = 2'd1,
        ST_SHORT   = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [4:0]  bytes_seen;
        logic [31:0] current_bits;
        logic [31:0] energy_bits;
        logic [31:0] minimum_bits;
        logic [31:0] average_bits;
        logic [15:0] sample_count;
    } t_result;

    // Expected header byte at positions 0 to 5
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] v;
        case (pos)
            3'd0:    v = 8'hAB;
            3'd1:    v = 8'h20;
            3'd2:    v = 8'h60;
            3'd3:    v = 8'h00;
            3'd4:    v = 8'h14;
            3'd5:    v = 8'h00;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

[rtl/probe_reply_frame_receiver.sv]
// Probe reply frame receiver: one word per cycle while the output is not stalled. An
// accepted word passes the input register, then the frame core into the result register.
// Throughput is one word per cycle unless the output stalls; the CRC-16 byte update is combinational.
// A word that closes a frame yields one result word; others yield none.
// Synchronous active-low reset closes any window and sets timeout to 150 ticks.
// Uses prfr_pkg, prfr_in_stage and prfr_frame_core.
`default_nettype none

module probe_reply_frame_receiver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [9:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_func,
    input  wire  [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_bytes_seen,
    output logic [31:0] o_current_bits,
    output logic [31:0] o_energy_bits,
    output logic [31:0] o_minimum_bits,
    output logic [31:0] o_average_bits,
    output logic [15:0] o_sample_count
);

    logic [9:0]        r_timeout;
    logic              r_out_valid;
    prfr_pkg::t_result r_out;

    prfr_pkg::t_item   in_item;
    prfr_pkg::t_item   st_item;
    logic              st_valid;
    logic              take;
    logic              res_valid;
    prfr_pkg::t_result res;

    assign in_item.func       = i_func;
    assign in_item.byte_value = i_byte_value;

    // Advance the staged word when the result register is free or draining
    assign take = st_valid && (!r_out_valid || i_out_ready);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= prfr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    prfr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    prfr_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (take),
        .i_item      (st_item),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_bytes_seen   = r_out.bytes_seen;
    assign o_current_bits = r_out.current_bits;
    assign o_energy_bits  = r_out.energy_bits;
    assign o_minimum_bits = r_out.minimum_bits;
    assign o_average_bits = r_out.average_bits;
    assign o_sample_count = r_out.sample_count;

endmodule

`default_nettype wire

[rtl/prfr_in_stage.sv]
// Input register of the probe reply frame receiver.
// Holds one accepted word until the frame core takes it. Uses prfr_pkg.
`default_nettype none

module prfr_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire prfr_pkg::t_item i_item,
    input  wire                 i_take,
    output logic                o_valid,
    output prfr_pkg::t_item     o_item
);

    logic            r_valid;
    prfr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[rtl/prfr_frame_core.sv]
// Frame state of the probe reply frame receiver: window, tick timeout,
// header check, CRC-16 and field capture. Uses prfr_pkg.
`default_nettype none

module prfr_frame_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_go,
    input  wire prfr_pkg::t_item i_item,
    input  wire [9:0]            i_timeout,
    output logic                 o_res_valid,
    output prfr_pkg::t_result    o_res
);

    logic        r_open,     n_open;
    logic [4:0]  r_index,    n_index;
    logic [9:0]  r_ticks,    n_ticks;
    logic [15:0] r_crc,      n_crc;
    logic        r_hdr_good, n_hdr_good;
    logic        r_lo_good,  n_lo_good;
    logic [31:0] r_current,  n_current;
    logic [31:0] r_energy,   n_energy;
    logic [15:0] r_count,    n_count;
    logic [31:0] r_minimum,  n_minimum;
    logic [31:0] r_average,  n_average;

    logic [7:0]  b;
    logic [4:0]  pos;
    logic [4:0]  d_cur, d_en, d_cnt, d_min, d_avg;
    logic [9:0]  ticks_inc;

    assign b   = i_item.byte_value;
    assign pos = r_index;
    assign d_cur = pos - prfr_pkg::OFS_CURRENT;
    assign d_en  = pos - prfr_pkg::OFS_ENERGY;
    assign d_cnt = pos - prfr_pkg::OFS_COUNT;
    assign d_min = pos - prfr_pkg::OFS_MINIMUM;
    assign d_avg = pos - prfr_pkg::OFS_AVERAGE;
    assign ticks_inc = r_ticks + 10'd1;

    always_comb begin
        n_open     = r_open;
        n_index    = r_index;
        n_ticks    = r_ticks;
        n_crc      = r_crc;
        n_hdr_good = r_hdr_good;
        n_lo_good  = r_lo_good;
        n_current  = r_current;
        n_energy   = r_energy;
        n_count    = r_count;
        n_minimum  = r_minimum;
        n_average  = r_average;
        o_res_valid = 1'b0;
        o_res.status = prfr_pkg::ST_SHORT;

        case (i_item.func)
            prfr_pkg::FUNC_START: begin
                n_open     = 1'b1;
                n_index    = '0;
                n_ticks    = '0;
                n_crc      = prfr_pkg::CRC_INIT;
                n_hdr_good = 1'b1;
                n_lo_good  = 1'b0;
                n_current  = '0;
                n_energy   = '0;
                n_count    = '0;
                n_minimum  = '0;
                n_average  = '0;
            end
            prfr_pkg::FUNC_BYTE: begin
                if (r_open && (pos < 5'(prfr_pkg::FRAME_LEN))) begin
                    if ((pos < 5'(prfr_pkg::HDR_LEN)) && (b != prfr_pkg::hdr_byte(pos[2:0]))) begin
                        n_hdr_good = 1'b0;
                    end
                    if (pos < 5'(prfr_pkg::CRC_SPAN)) begin
                        n_crc = prfr_pkg::crc_byte(r_crc, b);
                    end
                    if (d_cur < 5'd4) n_current[{d_cur[1:0], 3'b000} +: 8] = b;
                    if (d_en  < 5'd4) n_energy [{d_en[1:0],  3'b000} +: 8] = b;
                    if (d_cnt < 5'd2) n_count  [{d_cnt[0],   3'b000} +: 8] = b;
                    if (d_min < 5'd4) n_minimum[{d_min[1:0], 3'b000} +: 8] = b;
                    if (d_avg < 5'd4) n_average[{d_avg[1:0], 3'b000} +: 8] = b;
                    if (pos == 5'(prfr_pkg::CRC_SPAN)) begin
                        n_lo_good = (b == r_crc[7:0]);
                    end
                    n_index = pos + 5'd1;
                    // Last byte closes the frame
                    if (pos == 5'(prfr_pkg::FRAME_LEN - 1)) begin
                        n_open      = 1'b0;
                        o_res_valid = 1'b1;
                        if (!r_hdr_good) begin
                            o_res.status = prfr_pkg::ST_SHORT;
                        end else if (r_lo_good && (b == r_crc[15:8])) begin
                            o_res.status = prfr_pkg::ST_OK;
                        end else begin
                            o_res.status = prfr_pkg::ST_BAD_CRC;
                        end
                    end
                end
            end
            prfr_pkg::FUNC_TICK: begin
                if (r_open) begin
                    n_ticks = ticks_inc;
                    // Wrap to zero also closes the window
                    if ((ticks_inc >= i_timeout) || (ticks_inc == 10'd0)) begin
                        n_open       = 1'b0;
                        o_res_valid  = 1'b1;
                        o_res.status = (r_index == 5'd0) ? prfr_pkg::ST_NONE
                                                         : prfr_pkg::ST_SHORT;
                    end
                end
            end
            default: begin
            end
        endcase

        o_res_valid        = o_res_valid && i_go;
        o_res.bytes_seen   = n_index;
        o_res.current_bits = n_current;
        o_res.energy_bits  = n_energy;
        o_res.minimum_bits = n_minimum;
        o_res.average_bits = n_average;
        o_res.sample_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_index    <= '0;
            r_ticks    <= '0;
            r_crc      <= prfr_pkg::CRC_INIT;
            r_hdr_good <= 1'b1;
            r_lo_good  <= 1'b0;
            r_current  <= '0;
            r_energy   <= '0;
            r_count    <= '0;
            r_minimum  <= '0;
            r_average  <= '0;
        end else if (i_go) begin
            r_open     <= n_open;
            r_index    <= n_index;
            r_ticks    <= n_ticks;
            r_crc      <= n_crc;
            r_hdr_good <= n_hdr_good;
            r_lo_good  <= n_lo_good;
            r_current  <= n_current;
            r_energy   <= n_energy;
            r_count    <= n_count;
            r_minimum  <= n_minimum;
            r_average  <= n_average;
        end
    end

endmodule

`default_nettype wire
